@@ hw/rtl/cronp_pkg.sv @@
package cronp_pkg;

    // field sizes and widths
    localparam int NFIELDS   = 5;
    localparam int MIN_W     = 60;
    localparam int HOUR_W    = 24;
    localparam int DAY_W     = 31;
    localparam int MONTH_W   = 12;
    localparam int WDAY_W    = 7;
    localparam int MASK_W    = MIN_W;
    localparam int IDX_W     = $clog2(MASK_W);
    localparam int NUM_W     = 8;
    localparam int POS_W     = NUM_W + 1;
    localparam int SIZE_W    = $clog2(MASK_W + 1);
    localparam int FIDX_W    = $clog2(NFIELDS + 1);

    localparam logic [FIDX_W-1:0] FIDX_END = FIDX_W'(NFIELDS);

    // ascii codes
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [NUM_W-1:0] NUM_MAX = 8'hFF;

    typedef enum logic [5:0] {
        PH_START     = 6'b000001,
        PH_ITEM      = 6'b000010,
        PH_HIGH      = 6'b000100,
        PH_STEP      = 6'b001000,
        PH_STAR      = 6'b010000,
        PH_STAR_STEP = 6'b100000
    } t_phase;

    // result of offering one byte to the current field
    typedef struct packed {
        logic             take;
        logic             close;
        t_phase           phase;
        logic [NUM_W-1:0] low;
        logic [NUM_W-1:0] high;
        logic [NUM_W-1:0] step;
    } t_dec;

    // request to the mask walker
    typedef struct packed {
        logic              start;
        t_phase            phase;
        logic [NUM_W-1:0]  low;
        logic [NUM_W-1:0]  high;
        logic [NUM_W-1:0]  step;
        logic [FIDX_W-1:0] fidx;
    } t_walk_req;

    // walker status toward the sequencer
    typedef struct packed {
        logic             set;
        logic [IDX_W-1:0] idx;
        logic             done;
    } t_walk_st;

    function automatic logic [SIZE_W-1:0] field_size(input logic [FIDX_W-1:0] fidx);
        logic [SIZE_W-1:0] s;
        case (fidx)
            3'd0:    s = SIZE_W'(MIN_W);
            3'd1:    s = SIZE_W'(HOUR_W);
            3'd2:    s = SIZE_W'(DAY_W);
            3'd3:    s = SIZE_W'(MONTH_W);
            3'd4:    s = SIZE_W'(WDAY_W);
            default: s = '0;
        endcase
        return s;
    endfunction

    // v * 10 + digit, saturating
    function automatic logic [NUM_W-1:0] sat_digit(input logic [NUM_W-1:0] v,
                                                   input logic [7:0] c);
        logic [11:0] r;
        r = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {8'b0, c[3:0]};
        return (r > 12'(NUM_MAX)) ? NUM_MAX : r[NUM_W-1:0];
    endfunction

endpackage

@@ hw/rtl/cronp_if.sv @@
interface cronp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last;

    modport source (output valid, output char_in, output last, input ready);
    modport sink   (input valid, input char_in, input last, output ready);
endinterface

interface cronp_out_if;
    logic                         valid;
    logic                         ready;
    logic [cronp_pkg::MIN_W-1:0]   minute_mask;
    logic [cronp_pkg::HOUR_W-1:0]  hour_mask;
    logic [cronp_pkg::DAY_W-1:0]   day_mask;
    logic [cronp_pkg::MONTH_W-1:0] month_mask;
    logic [cronp_pkg::WDAY_W-1:0]  weekday_mask;
    logic                         stuck;

    modport source (output valid, output minute_mask, output hour_mask, output day_mask,
                    output month_mask, output weekday_mask, output stuck, input ready);
    modport sink   (input valid, input minute_mask, input hour_mask, input day_mask,
                    input month_mask, input weekday_mask, input stuck, output ready);
endinterface

@@ hw/rtl/cronp_decode.sv @@
module cronp_decode (
    input  cronp_pkg::t_phase              i_phase,
    input  logic [7:0]                     i_char,
    input  logic [cronp_pkg::NUM_W-1:0]    i_low,
    input  logic [cronp_pkg::NUM_W-1:0]    i_high,
    input  logic [cronp_pkg::NUM_W-1:0]    i_step,
    output cronp_pkg::t_dec                o_dec
);

    logic             is_digit;
    logic             is_blank;
    logic             opens_item;
    cronp_pkg::t_phase eff_phase;

    assign is_digit   = (i_char >= cronp_pkg::CH_ZERO) && (i_char <= cronp_pkg::CH_NINE);
    assign is_blank   = (i_char == cronp_pkg::CH_SPACE) || (i_char == cronp_pkg::CH_TAB)
                        || (i_char == cronp_pkg::CH_NL);
    assign opens_item = is_digit || (i_char == cronp_pkg::CH_DASH)
                        || (i_char == cronp_pkg::CH_SLASH) || (i_char == cronp_pkg::CH_COMMA);

    // a field start that sees an item character behaves as inside an item
    assign eff_phase = (i_phase == cronp_pkg::PH_START && opens_item) ? cronp_pkg::PH_ITEM
                                                                     : i_phase;

    always_comb begin
        o_dec.take  = 1'b0;
        o_dec.close = 1'b0;
        o_dec.phase = i_phase;
        o_dec.low   = i_low;
        o_dec.high  = i_high;
        o_dec.step  = i_step;
        unique case (eff_phase)
            cronp_pkg::PH_START: begin
                if (is_blank) begin
                    o_dec.take = 1'b1;
                end else if (i_char == cronp_pkg::CH_STAR) begin
                    o_dec.take  = 1'b1;
                    o_dec.phase = cronp_pkg::PH_STAR;
                end
            end
            cronp_pkg::PH_ITEM: begin
                o_dec.take  = is_digit || opens_item;
                o_dec.phase = cronp_pkg::PH_ITEM;
                if (is_digit) begin
                    o_dec.low = cronp_pkg::sat_digit(i_low, i_char);
                end else if (i_char == cronp_pkg::CH_DASH) begin
                    o_dec.high  = '0;
                    o_dec.phase = cronp_pkg::PH_HIGH;
                end else if (i_char == cronp_pkg::CH_SLASH) begin
                    o_dec.high  = i_low;
                    o_dec.phase = cronp_pkg::PH_STEP;
                end else if (i_char == cronp_pkg::CH_COMMA) begin
                    o_dec.close = 1'b1;
                end
            end
            cronp_pkg::PH_HIGH: begin
                if (is_digit) begin
                    o_dec.take = 1'b1;
                    o_dec.high = cronp_pkg::sat_digit(i_high, i_char);
                end else if (i_char == cronp_pkg::CH_SLASH) begin
                    o_dec.take  = 1'b1;
                    o_dec.phase = cronp_pkg::PH_STEP;
                end else if (i_char == cronp_pkg::CH_COMMA) begin
                    o_dec.take  = 1'b1;
                    o_dec.close = 1'b1;
                    o_dec.phase = cronp_pkg::PH_ITEM;
                end
            end
            cronp_pkg::PH_STEP: begin
                if (is_digit) begin
                    o_dec.take = 1'b1;
                    o_dec.step = cronp_pkg::sat_digit(i_step, i_char);
                end else if (i_char == cronp_pkg::CH_COMMA) begin
                    o_dec.take  = 1'b1;
                    o_dec.close = 1'b1;
                    o_dec.phase = cronp_pkg::PH_ITEM;
                end
            end
            cronp_pkg::PH_STAR: begin
                if (i_char == cronp_pkg::CH_SLASH) begin
                    o_dec.take  = 1'b1;
                    o_dec.phase = cronp_pkg::PH_STAR_STEP;
                end
            end
            cronp_pkg::PH_STAR_STEP: begin
                if (is_digit) begin
                    o_dec.take = 1'b1;
                    o_dec.step = cronp_pkg::sat_digit(i_step, i_char);
                end
            end
            default: begin
                o_dec.take = 1'b0;
            end
        endcase
        // a comma clears the item registers
        if (o_dec.close) begin
            o_dec.low  = '0;
            o_dec.high = '0;
            o_dec.step = '0;
        end
    end

endmodule

@@ hw/rtl/cronp_walk.sv @@
module cronp_walk (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cronp_pkg::t_walk_req i_req,
    output cronp_pkg::t_walk_st  o_st
);

    logic                           r_busy, n_busy;
    logic [cronp_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [cronp_pkg::NUM_W-1:0]    r_hi, n_hi;
    logic [cronp_pkg::NUM_W-1:0]    r_st, n_st;
    logic [cronp_pkg::SIZE_W-1:0]   r_size, n_size;
    logic                           in_range;
    logic [cronp_pkg::NUM_W-1:0]    start_lo;
    logic [cronp_pkg::NUM_W-1:0]    start_hi;

    assign in_range = (r_pos <= {1'b0, r_hi})
                      && (r_pos < cronp_pkg::POS_W'(r_size));

    // item bounds from the phase the item was closed in
    always_comb begin
        unique case (i_req.phase)
            cronp_pkg::PH_START, cronp_pkg::PH_ITEM: begin
                start_lo = i_req.low;
                start_hi = i_req.low;
            end
            cronp_pkg::PH_STAR, cronp_pkg::PH_STAR_STEP: begin
                start_lo = '0;
                start_hi = cronp_pkg::NUM_MAX;
            end
            default: begin
                start_lo = i_req.low;
                start_hi = i_req.high;
            end
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_pos  = r_pos;
        n_hi   = r_hi;
        n_st   = r_st;
        n_size = r_size;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_pos  = {1'b0, start_lo};
            n_hi   = start_hi;
            n_st   = (i_req.step == '0) ? cronp_pkg::NUM_W'(1) : i_req.step;
            n_size = cronp_pkg::field_size(i_req.fidx);
        end else if (r_busy) begin
            if (in_range) begin
                n_pos = r_pos + {1'b0, r_st};
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_hi   <= n_hi;
        r_st   <= n_st;
        r_size <= n_size;
    end

    assign o_st.set  = r_busy && in_range;
    assign o_st.idx  = r_pos[cronp_pkg::IDX_W-1:0];
    assign o_st.done = r_busy && !in_range;

endmodule

@@ hw/rtl/cron_spec_parser_top.sv @@
// cron spec parser: turns the text of a five-field cron spec into match masks
//
// i_in carries the spec one byte per beat (char_in) with last marking the
// final byte. o_out carries one beat per spec, after the byte with last set:
// minute (60 bits), hour (24), day of month (31), month (12) and weekday (7)
// masks plus the stuck flag for a byte that no field could take.
//
// the block works on one byte at a time and drops i_in.ready while busy.
// a plain byte goes through ST_CHAR and ST_TAIL before ready returns.
// closing an item (comma, field end, end of string) runs the mask walker:
// one adder and compare that visits low, low+step, ... and sets one mask
// bit per cycle while the sequencer waits in ST_FILL.
// a byte that ends a field and retries in the next one, or the last byte
// closing the remaining fields, chains up to five such closes.
// the result beat is held in o_out until the receiver takes it; i_in stays
// not ready meanwhile, then the parse state clears for the next spec.
// synchronous reset returns the block to the minute field, field start,
// with all item registers and the stuck flag cleared.
module cron_spec_parser_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cronp_in_if.sink           i_in,
    cronp_out_if.source        o_out
);

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CHAR = 5'b00010,
        ST_FILL = 5'b00100,
        ST_TAIL = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state                              r_state, n_state;
    logic [7:0]                          r_char, n_char;
    logic                                r_last, n_last;
    logic [cronp_pkg::FIDX_W-1:0]        r_fidx, n_fidx;
    cronp_pkg::t_phase                   r_phase, n_phase;
    logic [cronp_pkg::NUM_W-1:0]         r_low, n_low;
    logic [cronp_pkg::NUM_W-1:0]         r_high, n_high;
    logic [cronp_pkg::NUM_W-1:0]         r_step, n_step;
    logic [cronp_pkg::MASK_W-1:0]        r_accum, n_accum;
    logic                                r_stuck, n_stuck;
    logic                                r_end_field, n_end_field;
    logic                                r_retry, n_retry;
    logic [cronp_pkg::MASK_W-1:0]        r_done [cronp_pkg::NFIELDS];
    logic                                done_we;

    cronp_pkg::t_dec                     dec;
    cronp_pkg::t_walk_req                walk_req;
    cronp_pkg::t_walk_st                 walk_st;

    // byte classification for the current field
    cronp_decode u_decode (
        .i_phase (r_phase),
        .i_char  (r_char),
        .i_low   (r_low),
        .i_high  (r_high),
        .i_step  (r_step),
        .o_dec   (dec)
    );

    // shared step walker that builds one item's mask bits
    cronp_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (walk_req),
        .o_st    (walk_st)
    );

    assign i_in.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_char      = r_char;
        n_last      = r_last;
        n_fidx      = r_fidx;
        n_phase     = r_phase;
        n_low       = r_low;
        n_high      = r_high;
        n_step      = r_step;
        n_accum     = r_accum;
        n_stuck     = r_stuck;
        n_end_field = r_end_field;
        n_retry     = r_retry;
        done_we     = 1'b0;
        // the walker always sees the item as it stands before this cycle
        walk_req.start = 1'b0;
        walk_req.phase = r_phase;
        walk_req.low   = r_low;
        walk_req.high  = r_high;
        walk_req.step  = r_step;
        walk_req.fidx  = r_fidx;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_char  = i_in.char_in;
                    n_last  = i_in.last;
                    n_state = ST_CHAR;
                end
            end
            ST_CHAR: begin
                if (r_fidx == cronp_pkg::FIDX_END) begin
                    // all five fields done: trailing bytes are dropped
                    n_state = ST_TAIL;
                end else if (dec.take) begin
                    n_phase = dec.phase;
                    n_low   = dec.low;
                    n_high  = dec.high;
                    n_step  = dec.step;
                    if (dec.close) begin
                        walk_req.start = 1'b1;
                        n_end_field    = 1'b0;
                        n_retry        = 1'b0;
                        n_state        = ST_FILL;
                    end else begin
                        n_state = ST_TAIL;
                    end
                end else begin
                    // byte ends this field and is offered to the next one
                    if (r_phase == cronp_pkg::PH_START) begin
                        n_stuck = 1'b1;
                    end
                    walk_req.start = 1'b1;
                    n_phase        = cronp_pkg::PH_START;
                    n_low          = '0;
                    n_high         = '0;
                    n_step         = '0;
                    n_end_field    = 1'b1;
                    n_retry        = 1'b1;
                    n_state        = ST_FILL;
                end
            end
            ST_FILL: begin
                if (walk_st.set) begin
                    n_accum[walk_st.idx] = 1'b1;
                end
                if (walk_st.done) begin
                    if (r_end_field) begin
                        done_we = 1'b1;
                        n_accum = '0;
                        n_fidx  = r_fidx + cronp_pkg::FIDX_W'(1);
                        n_state = r_retry ? ST_CHAR : ST_TAIL;
                    end else begin
                        n_state = ST_TAIL;
                    end
                end
            end
            ST_TAIL: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (r_fidx != cronp_pkg::FIDX_END) begin
                    // end of string closes the open field, then each unstarted one
                    walk_req.start = 1'b1;
                    n_phase        = cronp_pkg::PH_START;
                    n_low          = '0;
                    n_high         = '0;
                    n_step         = '0;
                    n_end_field    = 1'b1;
                    n_retry        = 1'b0;
                    n_state        = ST_FILL;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_fidx  = '0;
                    n_phase = cronp_pkg::PH_START;
                    n_low   = '0;
                    n_high  = '0;
                    n_step  = '0;
                    n_accum = '0;
                    n_stuck = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fidx      <= '0;
            r_phase     <= cronp_pkg::PH_START;
            r_low       <= '0;
            r_high      <= '0;
            r_step      <= '0;
            r_accum     <= '0;
            r_stuck     <= 1'b0;
            r_end_field <= 1'b0;
            r_retry     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fidx      <= n_fidx;
            r_phase     <= n_phase;
            r_low       <= n_low;
            r_high      <= n_high;
            r_step      <= n_step;
            r_accum     <= n_accum;
            r_stuck     <= n_stuck;
            r_end_field <= n_end_field;
            r_retry     <= n_retry;
        end
    end

    // byte holding and finished field masks
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
        if (done_we) begin
            r_done[r_fidx] <= r_accum;
        end
    end

    assign o_out.valid        = (r_state == ST_OUT);
    assign o_out.minute_mask  = r_done[0];
    assign o_out.hour_mask    = r_done[1][cronp_pkg::HOUR_W-1:0];
    assign o_out.day_mask     = r_done[2][cronp_pkg::DAY_W-1:0];
    assign o_out.month_mask   = r_done[3][cronp_pkg::MONTH_W-1:0];
    assign o_out.weekday_mask = r_done[4][cronp_pkg::WDAY_W-1:0];
    assign o_out.stuck        = r_stuck;

endmodule

@@ hw/rtl/cronp_check.sv @@
module cronp_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [cronp_pkg::MIN_W-1:0]   i_minute_mask,
    input logic [cronp_pkg::HOUR_W-1:0]  i_hour_mask,
    input logic [cronp_pkg::WDAY_W-1:0]  i_weekday_mask,
    input logic                          i_stuck
);

    // a waiting result beat holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_minute_mask, i_hour_mask, i_weekday_mask, i_stuck}))
        else $error("result beat changed while stalled");

    // no new byte taken while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while result pending");

    // a result never follows a byte directly
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid)
        else $error("result one cycle after a byte");

    // a stuck spec closes every later field with value 0 only
    a_stuck_wday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stuck |-> i_weekday_mask == cronp_pkg::WDAY_W'(1))
        else $error("stuck spec with weekday mask other than value 0");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

endmodule

bind cron_spec_parser_top cronp_check u_cronp_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_minute_mask  (o_out.minute_mask),
    .i_hour_mask    (o_out.hour_mask),
    .i_weekday_mask (o_out.weekday_mask),
    .i_stuck        (o_out.stuck)
);

@@ verif/cron_mask_checker.sv @@
`timescale 1ns / 100ps

module cron_mask_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cronp_in_if   in_ch,
    cronp_out_if  out_ch,
    output int    o_pending,
    output int    o_fails
);

    typedef struct {
        logic [cronp_pkg::MIN_W-1:0]   minute;
        logic [cronp_pkg::HOUR_W-1:0]  hour;
        logic [cronp_pkg::DAY_W-1:0]   day;
        logic [cronp_pkg::MONTH_W-1:0] month;
        logic [cronp_pkg::WDAY_W-1:0]  weekday;
        logic                          stuck;
    } t_spec_masks;

    t_spec_masks      pending_masks [$];

    // shadow parse state
    cronp_pkg::t_phase            phase_q;
    int                           field_q;
    int unsigned                  low_q;
    int unsigned                  high_q;
    int unsigned                  step_q;
    logic [cronp_pkg::MASK_W-1:0] accum_q;
    logic [cronp_pkg::MASK_W-1:0] field_done [cronp_pkg::NFIELDS];
    logic                         stuck_q;

    int               fails;

    function automatic int span_of(input int f);
        case (f)
            0:       return cronp_pkg::MIN_W;
            1:       return cronp_pkg::HOUR_W;
            2:       return cronp_pkg::DAY_W;
            3:       return cronp_pkg::MONTH_W;
            4:       return cronp_pkg::WDAY_W;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned next_num(input int unsigned v, input logic [7:0] c);
        int unsigned r;
        r = v * 10 + (int'(c) - int'(cronp_pkg::CH_ZERO));
        return (r > 255) ? 255 : r;
    endfunction

    function automatic logic [cronp_pkg::MASK_W-1:0] item_bits(input int unsigned lo,
                                                                input int unsigned hi,
                                                                input int unsigned st,
                                                                input int size);
        logic [cronp_pkg::MASK_W-1:0] m;
        m = '0;
        if (st == 0) st = 1;
        for (int b = 0; b < size; b++) begin
            if (b >= lo && b <= hi && ((b - lo) % st) == 0) m[b] = 1'b1;
        end
        return m;
    endfunction

    task automatic clear_parse();
        phase_q = cronp_pkg::PH_START;
        field_q = 0;
        low_q   = 0;
        high_q  = 0;
        step_q  = 0;
        accum_q = '0;
        stuck_q = 1'b0;
        for (int f = 0; f < cronp_pkg::NFIELDS; f++) field_done[f] = '0;
    endtask

    task automatic close_item();
        int unsigned lo;
        int unsigned hi;
        lo = low_q;
        hi = high_q;
        if (phase_q == cronp_pkg::PH_START || phase_q == cronp_pkg::PH_ITEM) begin
            hi = lo;
        end else if (phase_q == cronp_pkg::PH_STAR || phase_q == cronp_pkg::PH_STAR_STEP) begin
            lo = 0;
            hi = 255;
        end
        if (field_q < cronp_pkg::NFIELDS)
            accum_q |= item_bits(lo, hi, step_q, span_of(field_q));
        low_q  = 0;
        high_q = 0;
        step_q = 0;
    endtask

    task automatic finish_field();
        close_item();
        if (field_q < cronp_pkg::NFIELDS) begin
            field_done[field_q] = accum_q;
            field_q++;
        end
        accum_q = '0;
        phase_q = cronp_pkg::PH_START;
    endtask

    // offer one byte to the current field, took = 0 if it cannot use it
    task automatic try_take(input logic [7:0] c, output bit took);
        bit is_dig;
        is_dig = (c >= cronp_pkg::CH_ZERO) && (c <= cronp_pkg::CH_NINE);
        took   = 1'b1;
        if (phase_q == cronp_pkg::PH_START) begin
            if (c == cronp_pkg::CH_SPACE || c == cronp_pkg::CH_TAB || c == cronp_pkg::CH_NL)
                return;
            if (c == cronp_pkg::CH_STAR) begin
                phase_q = cronp_pkg::PH_STAR;
                return;
            end
            if (!(is_dig || c == cronp_pkg::CH_DASH || c == cronp_pkg::CH_SLASH
                  || c == cronp_pkg::CH_COMMA)) begin
                took = 1'b0;
                return;
            end
            phase_q = cronp_pkg::PH_ITEM;
        end
        case (phase_q)
            cronp_pkg::PH_ITEM: begin
                if (is_dig) low_q = next_num(low_q, c);
                else if (c == cronp_pkg::CH_DASH) begin
                    high_q  = 0;
                    phase_q = cronp_pkg::PH_HIGH;
                end else if (c == cronp_pkg::CH_SLASH) begin
                    high_q  = low_q;
                    phase_q = cronp_pkg::PH_STEP;
                end else if (c == cronp_pkg::CH_COMMA) begin
                    close_item();
                    phase_q = cronp_pkg::PH_ITEM;
                end else took = 1'b0;
            end
            cronp_pkg::PH_HIGH: begin
                if (is_dig) high_q = next_num(high_q, c);
                else if (c == cronp_pkg::CH_SLASH) phase_q = cronp_pkg::PH_STEP;
                else if (c == cronp_pkg::CH_COMMA) begin
                    close_item();
                    phase_q = cronp_pkg::PH_ITEM;
                end else took = 1'b0;
            end
            cronp_pkg::PH_STEP: begin
                if (is_dig) step_q = next_num(step_q, c);
                else if (c == cronp_pkg::CH_COMMA) begin
                    close_item();
                    phase_q = cronp_pkg::PH_ITEM;
                end else took = 1'b0;
            end
            cronp_pkg::PH_STAR: begin
                if (c == cronp_pkg::CH_SLASH) phase_q = cronp_pkg::PH_STAR_STEP;
                else took = 1'b0;
            end
            cronp_pkg::PH_STAR_STEP: begin
                if (is_dig) step_q = next_num(step_q, c);
                else took = 1'b0;
            end
            default: took = 1'b0;
        endcase
    endtask

    // one accepted byte; on the final byte queue the masks it yields
    task automatic parse_byte(input logic [7:0] c, input logic fin);
        bit took;
        bit at_start;
        t_spec_masks m;
        took = 1'b0;
        while (field_q < cronp_pkg::NFIELDS && !took) begin
            at_start = (phase_q == cronp_pkg::PH_START);
            try_take(c, took);
            if (!took) begin
                if (at_start) stuck_q = 1'b1;
                finish_field();
            end
        end
        if (fin) begin
            while (field_q < cronp_pkg::NFIELDS) finish_field();
            m.minute  = field_done[0][cronp_pkg::MIN_W-1:0];
            m.hour    = field_done[1][cronp_pkg::HOUR_W-1:0];
            m.day     = field_done[2][cronp_pkg::DAY_W-1:0];
            m.month   = field_done[3][cronp_pkg::MONTH_W-1:0];
            m.weekday = field_done[4][cronp_pkg::WDAY_W-1:0];
            m.stuck   = stuck_q;
            pending_masks.push_back(m);
            clear_parse();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            if (fails < 10) $display("mismatch on %s: expected %h, got %h", name, want, got);
            fails++;
        end
    endtask

    task automatic check_result();
        t_spec_masks m;
        if (pending_masks.size() == 0) begin
            if (fails < 10) $display("result beat with no spec outstanding");
            fails++;
            return;
        end
        m = pending_masks.pop_front();
        check_field("minute_mask", 64'(m.minute), 64'(out_ch.minute_mask));
        check_field("hour_mask", 64'(m.hour), 64'(out_ch.hour_mask));
        check_field("day_mask", 64'(m.day), 64'(out_ch.day_mask));
        check_field("month_mask", 64'(m.month), 64'(out_ch.month_mask));
        check_field("weekday_mask", 64'(m.weekday), 64'(out_ch.weekday_mask));
        check_field("stuck", 64'(m.stuck), 64'(out_ch.stuck));
    endtask

    initial begin
        fails = 0;
        clear_parse();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            pending_masks.delete();
        end else begin
            if (in_ch.valid && in_ch.ready) parse_byte(in_ch.char_in, in_ch.last);
            if (out_ch.valid && out_ch.ready) check_result();
        end
        o_pending <= pending_masks.size();
        o_fails   <= fails;
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int RAND_BYTES = 2000;
    localparam int LIMIT      = 1_000_000;  // cycles, far above the slowest legal run

    logic i_clk;
    logic i_rst_n;
    bit   calm;          // long stretch with no idling on either side
    int   n_open;
    int   n_fail;
    int   cycles;
    int   rand_bytes;

    logic [7:0] spec_q [$];  // bytes of the spec being sent

    cronp_in_if  in_ch ();
    cronp_out_if out_ch ();

    cron_spec_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // watches both channels, predicts the masks and compares them
    cron_mask_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .o_pending (n_open),
        .o_fails   (n_fail)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: stalls about 36 percent of the time, never while calm
    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && (calm || $urandom_range(99) >= 36);
    end

    // one beat on the input channel; called and returning at a falling edge
    task automatic send_byte(input logic [7:0] c, input logic fin);
        while (!calm && $urandom_range(99) < 36) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.char_in <= c;
        in_ch.last    <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // send the queued spec with last on its final byte
    task automatic send_spec();
        for (int i = 0; i < spec_q.size(); i++) send_byte(spec_q[i], i == spec_q.size() - 1);
        spec_q.delete();
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++) spec_q.push_back(s[i]);
    endtask

    // decimal text of v, or nothing at all for a negative v (empty number)
    task automatic add_num(input int v);
        if (v < 0) return;
        if ($urandom_range(99) < 8) spec_q.push_back(cronp_pkg::CH_ZERO);  // leading zero
        load_text($sformatf("%0d", v));
    endtask

    function automatic int field_span(input int f);
        case (f)
            0:       return cronp_pkg::MIN_W;
            1:       return cronp_pkg::HOUR_W;
            2:       return cronp_pkg::DAY_W;
            3:       return cronp_pkg::MONTH_W;
            default: return cronp_pkg::WDAY_W;
        endcase
    endfunction

    // mostly in range, some past the field, some saturating, some empty
    function automatic int pick_val(input int size);
        int r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(size - 1);
        if (r < 85) return $urandom_range(255, size);
        if (r < 92) return $urandom_range(9999, 256);
        return -1;
    endfunction

    function automatic int pick_step();
        int r;
        r = $urandom_range(99);
        if (r < 10) return -1;
        if (r < 20) return 0;
        if (r < 90) return $urandom_range(15, 1);
        return $urandom_range(999, 16);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(2))
            0:       return cronp_pkg::CH_SPACE;
            1:       return cronp_pkg::CH_TAB;
            default: return cronp_pkg::CH_NL;
        endcase
    endfunction

    // star with optional step, or a list of a, a-b, a/s, a-b/s items
    task automatic add_field(input int size);
        int n_items;
        int kind;
        if ($urandom_range(99) < 20) begin
            spec_q.push_back(cronp_pkg::CH_STAR);
            if ($urandom_range(99) < 60) begin
                spec_q.push_back(cronp_pkg::CH_SLASH);
                add_num(pick_step());
            end
            return;
        end
        n_items = $urandom_range(3, 1);
        for (int i = 0; i < n_items; i++) begin
            kind = $urandom_range(3);
            if (i > 0) spec_q.push_back(cronp_pkg::CH_COMMA);
            add_num(pick_val(size));
            if (kind == 1 || kind == 3) begin
                spec_q.push_back(cronp_pkg::CH_DASH);
                add_num(pick_val(size));
            end
            if (kind >= 2) begin
                spec_q.push_back(cronp_pkg::CH_SLASH);
                add_num(pick_step());
            end
        end
    endtask

    task automatic build_spec();
        int n_fields;
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            // pure noise spec
            repeat ($urandom_range(6, 1)) spec_q.push_back(8'($urandom_range(255)));
            return;
        end
        n_fields = ($urandom_range(99) < 85) ? cronp_pkg::NFIELDS
                                             : $urandom_range(cronp_pkg::NFIELDS - 1);
        if ($urandom_range(99) < 10) spec_q.push_back(pick_blank());
        for (int f = 0; f < n_fields; f++) begin
            if (f > 0 && $urandom_range(99) < 85) begin
                repeat ($urandom_range(2, 1)) spec_q.push_back(pick_blank());
            end
            add_field(field_span(f));
        end
        // trailing junk after the last field
        if ($urandom_range(99) < 10) begin
            spec_q.push_back(pick_blank());
            repeat ($urandom_range(3, 1)) spec_q.push_back(8'($urandom_range(255)));
        end
        // broken specs: a stray byte somewhere, or cut short
        if ($urandom_range(99) < 15 && spec_q.size() > 0)
            spec_q.insert($urandom_range(spec_q.size() - 1), 8'($urandom_range(255)));
        if ($urandom_range(99) < 10 && spec_q.size() > 1) begin
            r = $urandom_range(spec_q.size() - 1, 1);
            while (spec_q.size() > r) void'(spec_q.pop_back());
        end
        if (spec_q.size() == 0) spec_q.push_back(8'($urandom_range(255)));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        calm          = 1'b0;
        cycles        = 0;
        rand_bytes    = 0;
        in_ch.valid   = 1'b0;
        in_ch.char_in = '0;
        in_ch.last    = 1'b0;
        out_ch.ready  = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero step on a star, tab and newline blanks, an empty range, a-b/s,
        // a saturating number, a slash with no step digits, end of string
        // closing the month and weekday fields
        load_text("*/0\t5-3,0-23/7\n300,1/");
        send_spec();
        // zero byte alone: stuck at once, every field gets value 0
        spec_q.push_back(8'h00);
        send_spec();
        // all-ones byte ends a range and sticks; the byte after it is ignored
        load_text("1-255");
        spec_q.push_back(8'hFF);
        load_text("7");
        send_spec();
        // fields with no separator, comma opening a field
        load_text("*2**/,");
        send_spec();

        while (rand_bytes < RAND_BYTES) begin
            build_spec();
            calm = (rand_bytes >= 700 && rand_bytes < 1100);
            rand_bytes += spec_q.size();
            send_spec();
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        // drain, then leave room for any stray beat
        while (n_open != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
